### rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

### rtl/core/crfp_pkg.sv
package crfp_pkg;

    localparam int PACKET_PAYLOAD_SIZE = 512;

    localparam logic [7:0] CH_HEAD  = 8'h55;
    localparam logic [7:0] CH_IMAGE = 8'h46;
    localparam logic [7:0] CH_END   = 8'h23;
    localparam logic [7:0] CH_INFO  = 8'h52;
    localparam logic [7:0] CH_IDQ   = 8'h43;
    localparam logic [7:0] CH_ACK_H = 8'h48;
    localparam logic [7:0] CH_ACK_E = 8'h45;
    localparam logic [7:0] CH_ACK_D = 8'h44;
    localparam logic [7:0] CH_ACK_Q = 8'h51;
    localparam logic [7:0] CH_NAK   = 8'h3F;

    localparam logic [3:0] EV_IMAGE    = 4'd0;
    localparam logic [3:0] EV_DATA     = 4'd1;
    localparam logic [3:0] EV_PKT_OK   = 4'd2;
    localparam logic [3:0] EV_PKT_BAD  = 4'd3;
    localparam logic [3:0] EV_SNAPSHOT = 4'd4;
    localparam logic [3:0] EV_ACK      = 4'd5;
    localparam logic [3:0] EV_NAK      = 4'd6;
    localparam logic [3:0] EV_ID_QUERY = 4'd7;
    localparam logic [3:0] EV_OTHER    = 4'd8;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [7:0]  camera_id;
        logic [7:0]  command_code;
        logic [15:0] packet_number;
        logic [8:0]  byte_index;
        logic [7:0]  byte_value;
        logic [15:0] payload_length;
        logic [31:0] file_offset;
        logic [31:0] snapshot_bytes;
        logic [15:0] snapshot_packets;
    } crfp_result_t;

endpackage

### rtl/core/camera_response_frame_parser.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  rx_byte
// out       output     out_valid / out_stall event_res .. snapshot_packets
// cfg       input      cfg_valid / cfg_ready cfg_data (parser_enabled)
//
// One byte per cycle while in_stall is low; each result is registered.
// Throughput is set by the input register feeding the result register.
// Reset clears the parser state and the valid flags; parsing starts enabled.
// A stalled result register with a byte waiting raises in_stall.
// cfg_ready is low while a byte waits in the input register.

`include "assert_macros.svh"

module camera_response_frame_parser #(
    parameter int PACKET_PAYLOAD_SIZE = crfp_pkg::PACKET_PAYLOAD_SIZE
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  event_res,
    output logic [7:0]  camera_id,
    output logic [7:0]  command_code,
    output logic [15:0] packet_number,
    output logic [8:0]  byte_index,
    output logic [7:0]  byte_value,
    output logic [15:0] payload_length,
    output logic [31:0] file_offset,
    output logic [31:0] snapshot_bytes,
    output logic [15:0] snapshot_packets,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    logic                  in_valid_reg;
    logic [7:0]            byte_reg;
    logic                  out_valid_reg;
    crfp_pkg::crfp_result_t result_reg;
    logic                  enabled_reg;

    logic                  process;
    logic                  res_valid;
    crfp_pkg::crfp_result_t res;

    assign in_stall  = in_valid_reg && out_valid_reg && out_stall;
    assign process   = in_valid_reg && !(out_valid_reg && out_stall);
    assign cfg_ready = !in_valid_reg;

    crfp_parse #(
        .PACKET_PAYLOAD_SIZE(PACKET_PAYLOAD_SIZE)
    ) u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (process),
        .enabled  (enabled_reg),
        .rx_byte  (byte_reg),
        .res_valid(res_valid),
        .res      (res)
    );

    // Hold the byte while the result side is stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (process && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && res_valid)
        begin
            result_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            enabled_reg <= cfg_data;
        end
    end

    assign out_valid        = out_valid_reg;
    assign event_res        = result_reg.event_res;
    assign camera_id        = result_reg.camera_id;
    assign command_code     = result_reg.command_code;
    assign packet_number    = result_reg.packet_number;
    assign byte_index       = result_reg.byte_index;
    assign byte_value       = result_reg.byte_value;
    assign payload_length   = result_reg.payload_length;
    assign file_offset      = result_reg.file_offset;
    assign snapshot_bytes   = result_reg.snapshot_bytes;
    assign snapshot_packets = result_reg.snapshot_packets;

    `ASSERT_CLK(a_byte_fields_zero, clk, rst_n,
        !out_valid_reg || result_reg.event_res == crfp_pkg::EV_IMAGE ||
        result_reg.event_res == crfp_pkg::EV_DATA ||
        (result_reg.byte_index == '0 && result_reg.byte_value == '0),
        "byte fields set outside a byte event")
    `ASSERT_CLK(a_packet_fields_zero, clk, rst_n,
        !out_valid_reg || result_reg.event_res == crfp_pkg::EV_PKT_OK ||
        result_reg.event_res == crfp_pkg::EV_PKT_BAD ||
        (result_reg.payload_length == '0 && result_reg.file_offset == '0),
        "packet fields set outside a packet end event")
    `ASSERT_NEXT(a_waiting_byte_held, clk, rst_n, in_stall,
        in_valid_reg && $stable(byte_reg),
        "waiting byte lost while stalled")

endmodule

### rtl/core/crfp_parse.sv
module crfp_parse #(
    parameter int PACKET_PAYLOAD_SIZE = crfp_pkg::PACKET_PAYLOAD_SIZE
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  enabled,
    input  logic [7:0]            rx_byte,
    output logic                  res_valid,
    output crfp_pkg::crfp_result_t res
);

    localparam logic [3:0] PH_HEADER  = 4'd0;
    localparam logic [3:0] PH_CMD     = 4'd1;
    localparam logic [3:0] PH_CAM     = 4'd2;
    localparam logic [3:0] PH_DATA    = 4'd3;
    localparam logic [3:0] PH_PID0    = 4'd4;
    localparam logic [3:0] PH_PID1    = 4'd5;
    localparam logic [3:0] PH_LEN0    = 4'd6;
    localparam logic [3:0] PH_LEN1    = 4'd7;
    localparam logic [3:0] PH_PAYLOAD = 4'd8;
    localparam logic [3:0] PH_SUM0    = 4'd9;
    localparam logic [3:0] PH_SUM1    = 4'd10;

    localparam logic [15:0] PAYLOAD_LIMIT = 16'(PACKET_PAYLOAD_SIZE);
    localparam logic [31:0] PAYLOAD_SIZE32 = 32'(PACKET_PAYLOAD_SIZE);

    logic [3:0]  phase_reg, phase_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  command_reg, command_next;
    logic [7:0]  camera_reg, camera_next;
    logic [15:0] pid_reg, pid_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  sum_low_reg, sum_low_next;
    logic [47:0] info_reg, info_next;

    logic [15:0] sum_plus;
    logic [15:0] count_inc;
    logic [15:0] sum_got;
    logic [3:0]  end_event;

    assign sum_plus  = sum_reg + {8'd0, rx_byte};
    assign count_inc = count_reg + 16'd1;
    assign sum_got   = {rx_byte, sum_low_reg};

    always_comb
    begin
        unique case (command_reg) inside
            crfp_pkg::CH_INFO:
                end_event = crfp_pkg::EV_SNAPSHOT;
            crfp_pkg::CH_IDQ:
                end_event = crfp_pkg::EV_ID_QUERY;
            crfp_pkg::CH_ACK_H, crfp_pkg::CH_ACK_E, crfp_pkg::CH_ACK_D, crfp_pkg::CH_ACK_Q:
                end_event = crfp_pkg::EV_ACK;
            crfp_pkg::CH_NAK:
                end_event = crfp_pkg::EV_NAK;
            default:
                end_event = crfp_pkg::EV_OTHER;
        endcase
    end

    always_comb
    begin
        phase_next   = phase_reg;
        sum_next     = sum_reg;
        command_next = command_reg;
        camera_next  = camera_reg;
        pid_next     = pid_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        sum_low_next = sum_low_reg;
        info_next    = info_reg;
        res_valid    = 1'b0;
        res          = '0;
        res.camera_id    = camera_reg;
        res.command_code = command_reg;

        if (step && enabled)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (rx_byte == crfp_pkg::CH_HEAD)
                    begin
                        sum_next   = {8'd0, crfp_pkg::CH_HEAD};
                        phase_next = PH_CMD;
                    end
                end
                PH_CMD:
                begin
                    sum_next     = sum_plus;
                    command_next = rx_byte;
                    count_next   = '0;
                    phase_next   = PH_CAM;
                end
                PH_CAM:
                begin
                    sum_next    = sum_plus;
                    camera_next = rx_byte;
                    count_next  = '0;
                    if (command_reg == crfp_pkg::CH_IMAGE)
                    begin
                        phase_next = PH_PID0;
                    end
                    else
                    begin
                        info_next  = '0;
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    res_valid = 1'b1;
                    if (rx_byte == crfp_pkg::CH_END)
                    begin
                        phase_next    = PH_HEADER;
                        res.event_res = end_event;
                        if (end_event == crfp_pkg::EV_SNAPSHOT)
                        begin
                            res.snapshot_bytes   = info_reg[31:0];
                            res.snapshot_packets = info_reg[47:32];
                        end
                    end
                    else
                    begin
                        res.event_res  = crfp_pkg::EV_DATA;
                        res.byte_index = count_reg[8:0];
                        res.byte_value = rx_byte;
                        if (count_reg < 16'd6)
                        begin
                            info_next[count_reg[2:0]*8 +: 8] = rx_byte;
                        end
                        if (count_reg != 16'hFFFF)
                        begin
                            count_next = count_inc;
                        end
                    end
                end
                PH_PID0:
                begin
                    sum_next   = sum_plus;
                    pid_next   = {8'd0, rx_byte};
                    phase_next = PH_PID1;
                end
                PH_PID1:
                begin
                    sum_next   = sum_plus;
                    pid_next   = {rx_byte, pid_reg[7:0]};
                    phase_next = PH_LEN0;
                end
                PH_LEN0:
                begin
                    sum_next    = sum_plus;
                    length_next = {8'd0, rx_byte};
                    phase_next  = PH_LEN1;
                end
                PH_LEN1:
                begin
                    sum_next    = sum_plus;
                    length_next = {rx_byte, length_reg[7:0]};
                    count_next  = '0;
                    phase_next  = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    if (count_reg < PAYLOAD_LIMIT)
                    begin
                        sum_next          = sum_plus;
                        res_valid         = 1'b1;
                        res.event_res     = crfp_pkg::EV_IMAGE;
                        res.packet_number = pid_reg;
                        res.byte_index    = count_reg[8:0];
                        res.byte_value    = rx_byte;
                    end
                    count_next = count_inc;
                    if ((length_reg >= 16'hFFFE) || (count_inc >= length_reg))
                    begin
                        phase_next = PH_SUM0;
                    end
                end
                PH_SUM0:
                begin
                    sum_low_next = rx_byte;
                    phase_next   = PH_SUM1;
                end
                PH_SUM1:
                begin
                    res_valid          = 1'b1;
                    phase_next         = PH_HEADER;
                    res.packet_number  = pid_reg;
                    res.payload_length = count_reg;
                    res.file_offset    = ({16'd0, pid_reg} - 32'd1) * PAYLOAD_SIZE32;
                    if (sum_got == sum_reg)
                    begin
                        sum_next      = '0;
                        res.event_res = crfp_pkg::EV_PKT_OK;
                    end
                    else
                    begin
                        res.event_res = crfp_pkg::EV_PKT_BAD;
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            sum_reg     <= '0;
            command_reg <= '0;
            camera_reg  <= '0;
            pid_reg     <= '0;
            length_reg  <= '0;
            count_reg   <= '0;
            sum_low_reg <= '0;
            info_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            sum_reg     <= sum_next;
            command_reg <= command_next;
            camera_reg  <= camera_next;
            pid_reg     <= pid_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            sum_low_reg <= sum_low_next;
            info_reg    <= info_next;
        end
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT = 1000000;

    typedef enum logic [3:0] {
        SEEK_HEAD,
        TAKE_CMD,
        TAKE_CAM,
        TAKE_DATA,
        TAKE_PID_LO,
        TAKE_PID_HI,
        TAKE_LEN_LO,
        TAKE_LEN_HI,
        TAKE_PAYLOAD,
        TAKE_SUM_LO,
        TAKE_SUM_HI
    } parse_step_t;

    class frame_event_tracker_t;
        bit           enabled = 1'b1;
        parse_step_t  step = SEEK_HEAD;
        logic [15:0]  sum_acc = '0;
        logic [7:0]   command = '0;
        logic [7:0]   camera = '0;
        logic [15:0]  pid = '0;
        logic [15:0]  len_field = '0;
        logic [15:0]  count = '0;
        logic [7:0]   sum_lo = '0;
        logic [47:0]  info = '0;
        crfp_pkg::crfp_result_t expected_events[$];
        int           fail_count = 0;

        function void set_enabled(logic v);
            enabled = v;
        endfunction

        function int pending_count();
            return expected_events.size();
        endfunction

        function void take_byte(logic [7:0] c);
            crfp_pkg::crfp_result_t r;
            logic [15:0]  biased;
            if (!enabled)
                return;
            r = '0;
            r.camera_id = camera;
            r.command_code = command;
            case (step)
                SEEK_HEAD:
                begin
                    if (c == crfp_pkg::CH_HEAD)
                    begin
                        sum_acc = 16'(crfp_pkg::CH_HEAD);
                        step = TAKE_CMD;
                    end
                end
                TAKE_CMD:
                begin
                    sum_acc += 16'(c);
                    command = c;
                    count = '0;
                    step = TAKE_CAM;
                end
                TAKE_CAM:
                begin
                    sum_acc += 16'(c);
                    camera = c;
                    count = '0;
                    if (command == crfp_pkg::CH_IMAGE)
                        step = TAKE_PID_LO;
                    else
                    begin
                        info = '0;
                        step = TAKE_DATA;
                    end
                end
                TAKE_DATA:
                begin
                    if (c == crfp_pkg::CH_END)
                    begin
                        step = SEEK_HEAD;
                        case (command)
                            crfp_pkg::CH_INFO:  r.event_res = crfp_pkg::EV_SNAPSHOT;
                            crfp_pkg::CH_IDQ:   r.event_res = crfp_pkg::EV_ID_QUERY;
                            crfp_pkg::CH_ACK_H, crfp_pkg::CH_ACK_E,
                            crfp_pkg::CH_ACK_D, crfp_pkg::CH_ACK_Q:
                                                r.event_res = crfp_pkg::EV_ACK;
                            crfp_pkg::CH_NAK:   r.event_res = crfp_pkg::EV_NAK;
                            default:            r.event_res = crfp_pkg::EV_OTHER;
                        endcase
                        if (r.event_res == crfp_pkg::EV_SNAPSHOT)
                        begin
                            r.snapshot_bytes = info[31:0];
                            r.snapshot_packets = info[47:32];
                        end
                    end
                    else
                    begin
                        r.event_res = crfp_pkg::EV_DATA;
                        r.byte_index = count[8:0];
                        r.byte_value = c;
                        if (count < 16'd6)
                            info[count * 8 +: 8] = c;
                        if (count != 16'hFFFF)
                            count++;
                    end
                    expected_events.push_back(r);
                end
                TAKE_PID_LO:
                begin
                    sum_acc += 16'(c);
                    pid = {8'h00, c};
                    step = TAKE_PID_HI;
                end
                TAKE_PID_HI:
                begin
                    sum_acc += 16'(c);
                    pid[15:8] = c;
                    step = TAKE_LEN_LO;
                end
                TAKE_LEN_LO:
                begin
                    sum_acc += 16'(c);
                    len_field = {8'h00, c};
                    step = TAKE_LEN_HI;
                end
                TAKE_LEN_HI:
                begin
                    sum_acc += 16'(c);
                    len_field[15:8] = c;
                    count = '0;
                    step = TAKE_PAYLOAD;
                end
                TAKE_PAYLOAD:
                begin
                    biased = len_field + 16'd2;
                    if (count < 16'(crfp_pkg::PACKET_PAYLOAD_SIZE))
                    begin
                        sum_acc += 16'(c);
                        r.event_res = crfp_pkg::EV_IMAGE;
                        r.packet_number = pid;
                        r.byte_index = count[8:0];
                        r.byte_value = c;
                        expected_events.push_back(r);
                    end
                    count = count + 16'd1;
                    if (biased < 16'd2 || count >= biased - 16'd2)
                        step = TAKE_SUM_LO;
                end
                TAKE_SUM_LO:
                begin
                    sum_lo = c;
                    step = TAKE_SUM_HI;
                end
                TAKE_SUM_HI:
                begin
                    if ({c, sum_lo} == sum_acc)
                    begin
                        r.event_res = crfp_pkg::EV_PKT_OK;
                        sum_acc = '0;
                    end
                    else
                        r.event_res = crfp_pkg::EV_PKT_BAD;
                    step = SEEK_HEAD;
                    r.packet_number = pid;
                    r.payload_length = count;
                    r.file_offset = 32'(({16'h0000, pid} - 32'd1)
                                        * crfp_pkg::PACKET_PAYLOAD_SIZE);
                    expected_events.push_back(r);
                end
                default:
                    step = SEEK_HEAD;
            endcase
        endfunction

        function void check_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
                fail_count++;
            end
        endfunction

        function void match_event(crfp_pkg::crfp_result_t got);
            crfp_pkg::crfp_result_t want;
            if (expected_events.size() == 0)
            begin
                $error("result with no pending request: event_res %0d", got.event_res);
                fail_count++;
                return;
            end
            want = expected_events.pop_front();
            check_field("event_res", 32'(want.event_res), 32'(got.event_res));
            check_field("camera_id", 32'(want.camera_id), 32'(got.camera_id));
            check_field("command_code", 32'(want.command_code), 32'(got.command_code));
            check_field("packet_number", 32'(want.packet_number), 32'(got.packet_number));
            check_field("byte_index", 32'(want.byte_index), 32'(got.byte_index));
            check_field("byte_value", 32'(want.byte_value), 32'(got.byte_value));
            check_field("payload_length", 32'(want.payload_length),
                        32'(got.payload_length));
            check_field("file_offset", want.file_offset, got.file_offset);
            check_field("snapshot_bytes", want.snapshot_bytes, got.snapshot_bytes);
            check_field("snapshot_packets", 32'(want.snapshot_packets),
                        32'(got.snapshot_packets));
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  event_res;
    logic [7:0]  camera_id;
    logic [7:0]  command_code;
    logic [15:0] packet_number;
    logic [8:0]  byte_index;
    logic [7:0]  byte_value;
    logic [15:0] payload_length;
    logic [31:0] file_offset;
    logic [31:0] snapshot_bytes;
    logic [15:0] snapshot_packets;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;

    frame_event_tracker_t tracker = new;
    logic [7:0]         tx_stream[$];
    int                 frame_bytes = 0;
    int                 burst_left = 0;
    bit                 steady_sender = 1'b0;
    bit                 hold_request = 1'b0;
    int                 hold_left = 0;
    int                 mood_left = 0;
    int                 stall_pct = 0;
    int unsigned        cycle_count = 0;

    camera_response_frame_parser uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .event_res(event_res),
        .camera_id(camera_id),
        .command_code(command_code),
        .packet_number(packet_number),
        .byte_index(byte_index),
        .byte_value(byte_value),
        .payload_length(payload_length),
        .file_offset(file_offset),
        .snapshot_bytes(snapshot_bytes),
        .snapshot_packets(snapshot_packets),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        crfp_pkg::crfp_result_t seen;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                tracker.set_enabled(cfg_data);
            if (in_valid && !in_stall)
                tracker.take_byte(rx_byte);
            if (out_valid && !out_stall)
            begin
                seen = {event_res, camera_id, command_code, packet_number, byte_index,
                        byte_value, payload_length, file_offset, snapshot_bytes,
                        snapshot_packets};
                tracker.match_event(seen);
            end
        end
    end

    // hold the result side on request, otherwise stall at a slowly changing rate
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mood_left == 0)
            begin
                mood_left = $urandom_range(32, 300);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 10;
                    2:       stall_pct = 35;
                    default: stall_pct = 70;
                endcase
            end
            mood_left--;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic logic [7:0] random_non_head();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == crfp_pkg::CH_HEAD);
        return b;
    endfunction

    function automatic logic [7:0] pick_command();
        logic [7:0] c;
        case ($urandom_range(0, 7))
            0:       c = crfp_pkg::CH_INFO;
            1:       c = crfp_pkg::CH_IDQ;
            2:       c = crfp_pkg::CH_ACK_H;
            3:       c = crfp_pkg::CH_ACK_E;
            4:       c = crfp_pkg::CH_ACK_D;
            5:       c = crfp_pkg::CH_ACK_Q;
            6:       c = crfp_pkg::CH_NAK;
            default:
            begin
                do
                    c = 8'($urandom);
                while (c == crfp_pkg::CH_IMAGE);
            end
        endcase
        return c;
    endfunction

    function automatic void put_byte(logic [7:0] b);
        tx_stream.push_back(b);
        frame_bytes++;
    endfunction

    // short_by drops payload bytes and appends as much trailing junk after the checksum
    function automatic void queue_image_packet(logic [7:0] cam, logic [15:0] pid,
                                               logic [15:0] len_field, int short_by, bit good);
        logic [15:0] sum;
        logic [7:0]  b;
        int          carried;
        carried = (len_field == 16'h0000 || len_field >= 16'hFFFE) ? 1 : int'(len_field);
        sum = 16'(crfp_pkg::CH_HEAD) + 16'(crfp_pkg::CH_IMAGE) + 16'(cam)
            + 16'(pid[7:0]) + 16'(pid[15:8])
            + 16'(len_field[7:0]) + 16'(len_field[15:8]);
        put_byte(crfp_pkg::CH_HEAD);
        put_byte(crfp_pkg::CH_IMAGE);
        put_byte(cam);
        put_byte(pid[7:0]);
        put_byte(pid[15:8]);
        put_byte(len_field[7:0]);
        put_byte(len_field[15:8]);
        for (int i = 0; i < carried - short_by; i++)
        begin
            b = 8'($urandom);
            put_byte(b);
            if (i < crfp_pkg::PACKET_PAYLOAD_SIZE)
                sum += 16'(b);
        end
        if (!good)
            sum ^= 16'(1) << $urandom_range(0, 15);
        put_byte(sum[7:0]);
        put_byte(sum[15:8]);
        repeat (short_by) put_byte(random_non_head());
    endfunction

    function automatic void queue_command_frame(logic [7:0] cmd, logic [7:0] cam, int ndata);
        logic [7:0] b;
        put_byte(crfp_pkg::CH_HEAD);
        put_byte(cmd);
        put_byte(cam);
        repeat (ndata)
        begin
            do
                b = 8'($urandom);
            while (b == crfp_pkg::CH_END);
            put_byte(b);
        end
        put_byte(crfp_pkg::CH_END);
    endfunction

    function automatic void queue_random_traffic(int budget);
        int          start;
        int          pick;
        int          carried;
        logic [15:0] len;
        logic [15:0] pid;
        logic [7:0]  cmd;
        start = frame_bytes;
        while (frame_bytes - start < budget)
        begin
            pick = $urandom_range(0, 99);
            pid = 16'($urandom);
            case ($urandom_range(0, 19))
                0:       pid = 16'h0000;
                1:       pid = 16'hFFFF;
                2:       pid = 16'h0001;
                default: ;
            endcase
            case ($urandom_range(0, 49))
                0:       len = 16'h0000;
                1:       len = 16'hFFFE;
                2:       len = 16'hFFFF;
                3:       len = 16'($urandom_range(513, 600));
                4, 5, 6: len = 16'($urandom_range(25, 300));
                default: len = 16'($urandom_range(1, 24));
            endcase
            carried = (len == 16'h0000 || len >= 16'hFFFE) ? 1 : int'(len);
            if (pick < 10)
                repeat ($urandom_range(1, 4)) tx_stream.push_back(random_non_head());
            else if (pick < 15)
            begin
                // drop a frame after its first bytes and let the next one run into it
                put_byte(crfp_pkg::CH_HEAD);
                if ($urandom_range(0, 1))
                    put_byte(pick_command());
                queue_command_frame(pick_command(), 8'($urandom), $urandom_range(0, 6));
            end
            else if (pick < 20)
                queue_image_packet(8'($urandom), pid, len,
                                   carried > 1 ? $urandom_range(1, carried - 1) : 0,
                                   1'b1);
            else if (pick < 60)
                queue_image_packet(8'($urandom), pid, len, 0, $urandom_range(0, 4) != 0);
            else
            begin
                cmd = pick_command();
                if (cmd == crfp_pkg::CH_INFO)
                    queue_command_frame(cmd, 8'($urandom),
                                        $urandom_range(0, 1) ? 6 : $urandom_range(0, 9));
                else
                    queue_command_frame(cmd, 8'($urandom), $urandom_range(0, 8));
            end
        end
    endfunction

    task automatic send_stream();
        logic [7:0] b;
        int         gap;
        while (tx_stream.size() > 0)
        begin
            if (burst_left == 0)
            begin
                if (!steady_sender)
                begin
                    gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20)
                                                      : $urandom_range(0, 3);
                    if (gap > 0)
                    begin
                        in_valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
                burst_left = $urandom_range(1, 48);
            end
            b = tx_stream.pop_front();
            in_valid <= 1'b1;
            rx_byte <= b;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            burst_left--;
        end
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        while (tracker.pending_count() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_parser_enable(logic v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [7:0] held_tail[$];
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_parser_enable(1'b1);

        tx_stream.push_back(8'h00);
        tx_stream.push_back(8'hFF);
        tx_stream.push_back(crfp_pkg::CH_END);
        queue_image_packet(8'h00, 16'h0000, 16'h0000, 0, 1'b1);
        queue_image_packet(8'hFF, 16'hFFFF, 16'hFFFF, 0, 1'b0);
        queue_image_packet(8'h5A, 16'h0001, 16'hFFFE, 0, 1'b1);
        queue_image_packet(8'hA5, 16'h0102, 16'h0003, 0, 1'b1);
        queue_image_packet(8'h3C, 16'h8000, 16'd520, 0, 1'b1);
        queue_command_frame(crfp_pkg::CH_INFO, 8'h11, 6);
        queue_command_frame(crfp_pkg::CH_INFO, 8'h12, 2);
        queue_command_frame(crfp_pkg::CH_INFO, 8'h13, 0);
        queue_command_frame(crfp_pkg::CH_INFO, 8'h14, 9);
        queue_command_frame(crfp_pkg::CH_IDQ, 8'h21, 0);
        queue_command_frame(crfp_pkg::CH_ACK_H, 8'h22, 1);
        queue_command_frame(crfp_pkg::CH_ACK_E, 8'h23, 2);
        queue_command_frame(crfp_pkg::CH_ACK_D, 8'h24, 0);
        queue_command_frame(crfp_pkg::CH_ACK_Q, 8'h25, 3);
        queue_command_frame(crfp_pkg::CH_NAK, 8'h26, 0);
        queue_command_frame(8'h00, 8'h27, 4);
        queue_command_frame(8'hFF, 8'h28, 1);
        send_stream();
        wait_idle();

        // disable in the middle of a packet, feed junk, then finish the packet
        queue_image_packet(8'h77, 16'h0203, 16'd12, 0, 1'b1);
        repeat (7) held_tail.push_front(tx_stream.pop_back());
        send_stream();
        wait_idle();
        write_parser_enable(1'b0);
        queue_random_traffic(40);
        send_stream();
        wait_idle();
        write_parser_enable(1'b1);
        tx_stream = held_tail;
        send_stream();
        wait_idle();

        queue_random_traffic(180);
        send_stream();
        wait_idle();
        write_parser_enable(1'b0);
        queue_random_traffic(30);
        send_stream();
        wait_idle();
        write_parser_enable(1'b1);

        hold_request = 1'b1;
        queue_random_traffic(110);
        send_stream();
        while (tracker.pending_count() > 0)
            @(posedge clk);
        queue_random_traffic(110);
        send_stream();
        wait_idle();
        write_parser_enable(1'b1);

        steady_sender = 1'b1;
        queue_random_traffic(90);
        send_stream();
        steady_sender = 1'b0;
        queue_random_traffic(110);
        send_stream();

        while (tracker.pending_count() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (tracker.pending_count() != 0)
        begin
            $error("%0d results never arrived", tracker.pending_count());
            tracker.fail_count++;
        end
        if (tracker.fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/crfp_pkg.sv
rtl/core/crfp_parse.sv
rtl/core/camera_response_frame_parser.sv
dv/testbench.sv
